// ===== hdl/mvnb_pkg.sv =====
// Shared constants, word types and codes for the vertex normal and bounds block.
package mvnb_pkg;

  localparam int MaxVertices = 4096;
  localparam int CoordBits   = 24;
  localparam int NormalBits  = 16;
  localparam int CountBits   = $clog2(MaxVertices) + 1;
  localparam int AddrBits    = $clog2(MaxVertices);
  localparam int IndexBits   = 16;
  localparam int SumBits     = 64;
  localparam int EdgeBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * EdgeBits;
  localparam int FaceBits    = ProdBits + 1;
  localparam int MagBits     = 30;
  localparam int NormFrac    = NormalBits - 1;
  localparam int NumBits     = MagBits + NormFrac + 1;
  localparam int StepBits    = $clog2(NumBits);
  localparam int SqBits      = 2 * MagBits + 2;
  localparam int RootBits    = MagBits + 2;
  localparam int RemBits     = RootBits + 1;

  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpLoad  = 2'd1;
  localparam logic [1:0] OpTri   = 2'd2;
  localparam logic [1:0] OpQuery = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StSkipped  = 2'd2;
  localparam logic [1:0] StBadIndex = 2'd3;

  typedef struct packed {
    logic [1:0]                  op;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
    logic [IndexBits-1:0]        tri_v0;
    logic [IndexBits-1:0]        tri_v1;
    logic [IndexBits-1:0]        tri_v2;
    logic [IndexBits-1:0]        vertex_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [NormalBits-1:0] normal_x;
    logic signed [NormalBits-1:0] normal_y;
    logic signed [NormalBits-1:0] normal_z;
    logic signed [CoordBits-1:0]  box_min_x;
    logic signed [CoordBits-1:0]  box_min_y;
    logic signed [CoordBits-1:0]  box_min_z;
    logic signed [CoordBits-1:0]  box_max_x;
    logic signed [CoordBits-1:0]  box_max_y;
    logic signed [CoordBits-1:0]  box_max_z;
    logic [CountBits-1:0]         loaded_count;
  } out_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [SumBits-1:0] x;
    logic signed [SumBits-1:0] y;
    logic signed [SumBits-1:0] z;
  } sum_t;

  typedef struct packed {
    logic signed [NormalBits-1:0] x;
    logic signed [NormalBits-1:0] y;
    logic signed [NormalBits-1:0] z;
  } norm_t;

endpackage

// ===== hdl/mesh_vertex_normals_and_bounds.sv =====
// Top level: vertex and normal-sum memories, operation sequencer, face product and bounds.
// Start, load and rejected words go to the done state, which loads the output register
// once it is free. A triangle makes three position reads, six products on one multiplier
// and a sum read and write per corner; a query waits on the normalizer's shift, root and
// three divides, or its zero check. One word at a time; a finished result waits in the
// output register. Reset clears the count, the box and the handshake state, not memories.
module mesh_vertex_normals_and_bounds import mvnb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PRD   = 10'b0000000010,
    S_EDGE  = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_SRD   = 10'b0000010000,
    S_SWR   = 10'b0000100000,
    S_QRD   = 10'b0001000000,
    S_QWAIT = 10'b0010000000,
    S_NORM  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  function automatic logic signed [SumBits-1:0] sat_add(
    input logic signed [SumBits-1:0]  a,
    input logic signed [FaceBits-1:0] f
  );
    logic signed [SumBits-1:0] b;
    logic signed [SumBits-1:0] r;
    b = SumBits'(f);
    r = a + b;
    if (a[SumBits-1] == b[SumBits-1] && r[SumBits-1] != a[SumBits-1]) begin
      r = a[SumBits-1] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
    end
    return r;
  endfunction

  state_e state_q;
  in_word_t req_q;
  logic [1:0] status_q;
  logic [2:0] cnt_q;
  pos_t pa_q [3];
  logic signed [EdgeBits-1:0] e1_q [3];
  logic signed [EdgeBits-1:0] e2_q [3];
  logic signed [ProdBits-1:0] prod_q;
  logic signed [FaceBits-1:0] face_q [3];
  pos_t low_q, high_q;
  logic [CountBits-1:0] total_q;
  norm_t nrm_q;
  out_word_t out_q;
  logic out_valid_q;

  logic accept, full, first, load_we, tri_bad, q_bad, norm_start, norm_done;
  logic [IndexBits-1:0] total_ext, corner_idx;
  logic signed [EdgeBits-1:0] ma, mb;
  logic pos_we, sum_we;
  logic [AddrBits-1:0] pos_raddr, sum_raddr, sum_waddr;
  pos_t pos_wdata, pos_rdata;
  sum_t sum_wdata, sum_rdata, sum_upd;
  norm_t norm_res;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign total_ext  = {{(IndexBits-CountBits){1'b0}}, total_q};
  assign full       = (total_q == CountBits'(MaxVertices));
  assign first      = (total_q == '0);
  assign load_we    = accept && in_data_i.op == OpLoad && !full;
  assign tri_bad    = in_data_i.tri_v0 >= total_ext || in_data_i.tri_v1 >= total_ext
                      || in_data_i.tri_v2 >= total_ext;
  assign q_bad      = in_data_i.vertex_index >= total_ext;
  assign norm_start = (state_q == S_QWAIT);

  always_comb begin
    case (cnt_q)
      3'd0:    corner_idx = req_q.tri_v0;
      3'd1:    corner_idx = req_q.tri_v1;
      default: corner_idx = req_q.tri_v2;
    endcase
    case (cnt_q)
      3'd0:    begin ma = e1_q[1]; mb = e2_q[2]; end
      3'd1:    begin ma = e1_q[2]; mb = e2_q[1]; end
      3'd2:    begin ma = e1_q[2]; mb = e2_q[0]; end
      3'd3:    begin ma = e1_q[0]; mb = e2_q[2]; end
      3'd4:    begin ma = e1_q[0]; mb = e2_q[1]; end
      default: begin ma = e1_q[1]; mb = e2_q[0]; end
    endcase
  end

  assign pos_we    = load_we;
  assign pos_wdata = '{x: in_data_i.pos_x, y: in_data_i.pos_y, z: in_data_i.pos_z};
  assign pos_raddr = corner_idx[AddrBits-1:0];

  assign sum_upd.x = sat_add(sum_rdata.x, face_q[0]);
  assign sum_upd.y = sat_add(sum_rdata.y, face_q[1]);
  assign sum_upd.z = sat_add(sum_rdata.z, face_q[2]);
  assign sum_we    = load_we || state_q == S_SWR;
  assign sum_waddr = load_we ? total_q[AddrBits-1:0] : corner_idx[AddrBits-1:0];
  assign sum_wdata = load_we ? '0 : sum_upd;
  assign sum_raddr = (state_q == S_QRD) ? req_q.vertex_index[AddrBits-1:0]
                                        : corner_idx[AddrBits-1:0];

  mvnb_ram #(.Width($bits(pos_t)), .Depth(MaxVertices)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (total_q[AddrBits-1:0]),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  mvnb_ram #(.Width($bits(sum_t)), .Depth(MaxVertices)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  mvnb_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .sum_i   (sum_rdata),
    .done_o  (norm_done),
    .norm_o  (norm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q    <= in_data_i;
            status_q <= StOk;
            nrm_q    <= '0;
            cnt_q    <= '0;
            state_q  <= S_DONE;
            unique case (in_data_i.op)
              OpStart: begin
                total_q <= '0;
                low_q   <= '0;
                high_q  <= '0;
              end
              OpLoad: begin
                if (full) begin
                  status_q <= StFull;
                end else begin
                  total_q <= total_q + 1'b1;
                  if (first || in_data_i.pos_x < low_q.x)  low_q.x  <= in_data_i.pos_x;
                  if (first || in_data_i.pos_y < low_q.y)  low_q.y  <= in_data_i.pos_y;
                  if (first || in_data_i.pos_z < low_q.z)  low_q.z  <= in_data_i.pos_z;
                  if (first || in_data_i.pos_x > high_q.x) high_q.x <= in_data_i.pos_x;
                  if (first || in_data_i.pos_y > high_q.y) high_q.y <= in_data_i.pos_y;
                  if (first || in_data_i.pos_z > high_q.z) high_q.z <= in_data_i.pos_z;
                end
              end
              OpTri: begin
                if (tri_bad) begin
                  status_q <= StSkipped;
                end else begin
                  state_q <= S_PRD;
                end
              end
              default: begin
                if (q_bad) begin
                  status_q <= StBadIndex;
                end else begin
                  state_q <= S_QRD;
                end
              end
            endcase
          end
        end
        S_PRD: begin
          case (cnt_q)
            3'd1:    pa_q[0] <= pos_rdata;
            3'd2:    pa_q[1] <= pos_rdata;
            3'd3:    pa_q[2] <= pos_rdata;
            default: ;
          endcase
          if (cnt_q == 3'd3) begin
            state_q <= S_EDGE;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_EDGE: begin
          e1_q[0] <= EdgeBits'(pa_q[1].x) - EdgeBits'(pa_q[0].x);
          e1_q[1] <= EdgeBits'(pa_q[1].y) - EdgeBits'(pa_q[0].y);
          e1_q[2] <= EdgeBits'(pa_q[1].z) - EdgeBits'(pa_q[0].z);
          e2_q[0] <= EdgeBits'(pa_q[2].x) - EdgeBits'(pa_q[0].x);
          e2_q[1] <= EdgeBits'(pa_q[2].y) - EdgeBits'(pa_q[0].y);
          e2_q[2] <= EdgeBits'(pa_q[2].z) - EdgeBits'(pa_q[0].z);
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q <= ma * mb;
          case (cnt_q)
            3'd1:    face_q[0] <= FaceBits'(prod_q);
            3'd2:    face_q[0] <= face_q[0] - FaceBits'(prod_q);
            3'd3:    face_q[1] <= FaceBits'(prod_q);
            3'd4:    face_q[1] <= face_q[1] - FaceBits'(prod_q);
            3'd5:    face_q[2] <= FaceBits'(prod_q);
            3'd6:    face_q[2] <= face_q[2] - FaceBits'(prod_q);
            default: ;
          endcase
          if (cnt_q == 3'd6) begin
            cnt_q   <= '0;
            state_q <= S_SRD;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_SRD: begin
          state_q <= S_SWR;
        end
        S_SWR: begin
          if (cnt_q == 3'd2) begin
            state_q <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + 3'd1;
            state_q <= S_SRD;
          end
        end
        S_QRD: begin
          state_q <= S_QWAIT;
        end
        S_QWAIT: begin
          state_q <= S_NORM;
        end
        S_NORM: begin
          if (norm_done) begin
            nrm_q   <= norm_res;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.status       <= status_q;
            out_q.normal_x     <= nrm_q.x;
            out_q.normal_y     <= nrm_q.y;
            out_q.normal_z     <= nrm_q.z;
            out_q.box_min_x    <= low_q.x;
            out_q.box_min_y    <= low_q.y;
            out_q.box_min_z    <= low_q.z;
            out_q.box_max_x    <= high_q.x;
            out_q.box_max_y    <= high_q.y;
            out_q.box_max_z    <= high_q.z;
            out_q.loaded_count <= total_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/mvnb_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module mvnb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mvnb_norm.sv =====
// Iterative normalizer: magnitude shift, sum of squares, square root and three divides.
module mvnb_norm import mvnb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  sum_t  sum_i,
  output logic  done_o,
  output norm_t norm_o
);

  typedef enum logic [5:0] {
    NS_IDLE   = 6'b000001,
    NS_SHIFT  = 6'b000010,
    NS_SQUARE = 6'b000100,
    NS_ROOT   = 6'b001000,
    NS_DLOAD  = 6'b010000,
    NS_DIV    = 6'b100000
  } nstate_e;

  nstate_e state_q;
  logic [SumBits-1:0] mag_q [3];
  logic [2:0] neg_q;
  logic [1:0] cnt_q;
  logic [StepBits-1:0] step_q;
  logic [2*MagBits-1:0] prod_q;
  logic [SqBits-1:0] sq_q, v_q, root_q, bit_q, trial;
  logic [RootBits-1:0] len_q;
  logic [NumBits-1:0] num_q, quo_q, q_nx;
  logic [RemBits-1:0] rem_q, rem_t, rem_nx;
  logic ge;
  logic signed [NormalBits-1:0] res_q [3];
  logic done_q;
  logic [SumBits-1:0] mag_in [3];
  logic [MagBits-1:0] sq_in, div_in;
  logic [NormFrac-1:0] n_sat;
  logic [NormalBits-1:0] n_pos;
  logic neg_sel;

  assign mag_in[0] = sum_i.x[SumBits-1] ? -sum_i.x : sum_i.x;
  assign mag_in[1] = sum_i.y[SumBits-1] ? -sum_i.y : sum_i.y;
  assign mag_in[2] = sum_i.z[SumBits-1] ? -sum_i.z : sum_i.z;

  always_comb begin
    case (cnt_q)
      2'd0:    sq_in = mag_q[0][MagBits-1:0];
      2'd1:    sq_in = mag_q[1][MagBits-1:0];
      2'd2:    sq_in = mag_q[2][MagBits-1:0];
      default: sq_in = '0;
    endcase
    case (cnt_q)
      2'd0:    begin div_in = mag_q[0][MagBits-1:0]; neg_sel = neg_q[0]; end
      2'd1:    begin div_in = mag_q[1][MagBits-1:0]; neg_sel = neg_q[1]; end
      default: begin div_in = mag_q[2][MagBits-1:0]; neg_sel = neg_q[2]; end
    endcase
  end

  assign trial  = root_q + bit_q;
  assign rem_t  = {rem_q[RemBits-2:0], num_q[NumBits-1]};
  assign ge     = rem_t >= {1'b0, len_q};
  assign rem_nx = ge ? rem_t - {1'b0, len_q} : rem_t;
  assign q_nx   = {quo_q[NumBits-2:0], ge};
  assign n_sat  = (|q_nx[NumBits-1:NormFrac]) ? {NormFrac{1'b1}} : q_nx[NormFrac-1:0];
  assign n_pos  = {1'b0, n_sat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        NS_IDLE: begin
          if (start_i) begin
            mag_q[0] <= mag_in[0];
            mag_q[1] <= mag_in[1];
            mag_q[2] <= mag_in[2];
            neg_q    <= {sum_i.z[SumBits-1], sum_i.y[SumBits-1], sum_i.x[SumBits-1]};
            if ((mag_in[0] | mag_in[1] | mag_in[2]) == '0) begin
              res_q[0] <= '0;
              res_q[1] <= {1'b0, {NormFrac{1'b1}}};
              res_q[2] <= '0;
              done_q   <= 1'b1;
            end else begin
              state_q <= NS_SHIFT;
            end
          end
        end
        NS_SHIFT: begin
          if (|((mag_q[0] | mag_q[1] | mag_q[2]) >> MagBits)) begin
            mag_q[0] <= mag_q[0] >> 1;
            mag_q[1] <= mag_q[1] >> 1;
            mag_q[2] <= mag_q[2] >> 1;
          end else begin
            state_q <= NS_SQUARE;
            cnt_q   <= '0;
            sq_q    <= '0;
          end
        end
        NS_SQUARE: begin
          prod_q <= sq_in * sq_in;
          if (cnt_q != 2'd0) begin
            sq_q <= sq_q + SqBits'(prod_q);
          end
          if (cnt_q == 2'd3) begin
            state_q <= NS_ROOT;
            cnt_q   <= '0;
            root_q  <= '0;
            bit_q   <= SqBits'(1) << (SqBits - 2);
            v_q     <= sq_q + SqBits'(prod_q);
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        NS_ROOT: begin
          if (v_q >= trial) begin
            v_q    <= v_q - trial;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            len_q   <= v_q >= trial ? RootBits'((root_q >> 1) + bit_q)
                                    : RootBits'(root_q >> 1);
            state_q <= NS_DLOAD;
          end
        end
        NS_DLOAD: begin
          num_q   <= {1'b0, div_in, {NormFrac{1'b0}}} + NumBits'(len_q >> 1);
          rem_q   <= '0;
          quo_q   <= '0;
          step_q  <= '0;
          state_q <= NS_DIV;
        end
        NS_DIV: begin
          rem_q  <= rem_nx;
          quo_q  <= q_nx;
          num_q  <= num_q << 1;
          step_q <= step_q + 1'b1;
          if (step_q == StepBits'(NumBits - 1)) begin
            case (cnt_q)
              2'd0:    res_q[0] <= neg_sel ? -n_pos : n_pos;
              2'd1:    res_q[1] <= neg_sel ? -n_pos : n_pos;
              default: res_q[2] <= neg_sel ? -n_pos : n_pos;
            endcase
            if (cnt_q == 2'd2) begin
              state_q <= NS_IDLE;
              done_q  <= 1'b1;
            end else begin
              cnt_q   <= cnt_q + 2'd1;
              state_q <= NS_DLOAD;
            end
          end
        end
        default: state_q <= NS_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign norm_o.x = res_q[0];
  assign norm_o.y = res_q[1];
  assign norm_o.z = res_q[2];

endmodule

// ===== sim/tb_mesh_vertex_normals_and_bounds.sv =====
// Self-checking testbench for the vertex normal and bounds block with random stimulus and stalls.
module tb_mesh_vertex_normals_and_bounds;
  import mvnb_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      in_ready_q = 1'b0;

  mesh_vertex_normals_and_bounds DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  always #5 clk = ~clk;

  localparam logic signed [CoordBits-1:0] CMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] CMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic signed [63:0] SumMax = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SumMin = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] NormOne = 64'd1 << NormFrac;

  pos_t        vert_pos [MaxVertices];
  sum_t        vert_sum [MaxVertices];
  pos_t        box_lo = '0;
  pos_t        box_hi = '0;
  int unsigned vert_count = 0;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int        send_idle_pct, recv_stall_pct;
  bit        failed = 1'b0;
  longint    cycles = 0;

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (!a[63] && !b[63] && r[63]) return SumMax;
    if (a[63] && b[63] && !r[63]) return SumMin;
    return r;
  endfunction

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic norm_t unit_normal(sum_t s);
    logic signed [63:0] sv [3];
    logic [63:0] m [3];
    logic [63:0] big, sq, len, n;
    logic signed [NormalBits-1:0] r [3];
    int sh;
    norm_t res;
    sv[0] = s.x; sv[1] = s.y; sv[2] = s.z;
    big = 0; sq = 0; sh = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = sv[k][63] ? 64'd0 - sv[k] : sv[k];
      if (m[k] > big) big = m[k];
    end
    if (big == 0) begin
      res.x = '0; res.y = NormalBits'(NormOne - 1); res.z = '0;
      return res;
    end
    while ((big >> sh) >= (64'd1 << 30)) sh++;
    for (int k = 0; k < 3; k++) begin
      m[k] >>= sh;
      sq += m[k] * m[k];
    end
    len = sqrt_floor(sq);
    for (int k = 0; k < 3; k++) begin
      n = (m[k] * NormOne + len / 2) / len;
      if (n > NormOne - 1) n = NormOne - 1;
      r[k] = sv[k][63] ? -n[NormalBits-1:0] : n[NormalBits-1:0];
    end
    res.x = r[0]; res.y = r[1]; res.z = r[2];
    return res;
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    out_word_t o;
    logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, fx, fy, fz;
    int unsigned ca, cb, cc, ci;
    pos_t p;
    norm_t nv;
    o = '0;
    o.status = StOk;
    case (w.op)
      OpStart: begin
        vert_count = 0;
        box_lo = '0;
        box_hi = '0;
      end
      OpLoad: begin
        if (vert_count >= MaxVertices) begin
          o.status = StFull;
        end else begin
          p.x = w.pos_x; p.y = w.pos_y; p.z = w.pos_z;
          vert_pos[vert_count] = p;
          vert_sum[vert_count] = '0;
          if (vert_count == 0 || p.x < box_lo.x) box_lo.x = p.x;
          if (vert_count == 0 || p.y < box_lo.y) box_lo.y = p.y;
          if (vert_count == 0 || p.z < box_lo.z) box_lo.z = p.z;
          if (vert_count == 0 || p.x > box_hi.x) box_hi.x = p.x;
          if (vert_count == 0 || p.y > box_hi.y) box_hi.y = p.y;
          if (vert_count == 0 || p.z > box_hi.z) box_hi.z = p.z;
          vert_count++;
        end
      end
      OpTri: begin
        ca = w.tri_v0; cb = w.tri_v1; cc = w.tri_v2;
        if (ca >= vert_count || cb >= vert_count || cc >= vert_count) begin
          o.status = StSkipped;
        end else begin
          e1x = 64'(vert_pos[cb].x) - 64'(vert_pos[ca].x);
          e1y = 64'(vert_pos[cb].y) - 64'(vert_pos[ca].y);
          e1z = 64'(vert_pos[cb].z) - 64'(vert_pos[ca].z);
          e2x = 64'(vert_pos[cc].x) - 64'(vert_pos[ca].x);
          e2y = 64'(vert_pos[cc].y) - 64'(vert_pos[ca].y);
          e2z = 64'(vert_pos[cc].z) - 64'(vert_pos[ca].z);
          fx = e1y * e2z - e1z * e2y;
          fy = e1z * e2x - e1x * e2z;
          fz = e1x * e2y - e1y * e2x;
          for (int k = 0; k < 3; k++) begin
            ci = (k == 0) ? ca : (k == 1) ? cb : cc;
            vert_sum[ci].x = add_sat(vert_sum[ci].x, fx);
            vert_sum[ci].y = add_sat(vert_sum[ci].y, fy);
            vert_sum[ci].z = add_sat(vert_sum[ci].z, fz);
          end
        end
      end
      default: begin
        if (w.vertex_index >= vert_count) begin
          o.status = StBadIndex;
        end else begin
          nv = unit_normal(vert_sum[w.vertex_index]);
          o.normal_x = nv.x; o.normal_y = nv.y; o.normal_z = nv.z;
        end
      end
    endcase
    o.box_min_x = box_lo.x; o.box_min_y = box_lo.y; o.box_min_z = box_lo.z;
    o.box_max_x = box_hi.x; o.box_max_y = box_hi.y; o.box_max_z = box_hi.z;
    o.loaded_count = vert_count[CountBits-1:0];
    return o;
  endfunction

  function automatic in_word_t make_word(logic [1:0] op);
    in_word_t w;
    w = in_word_t'($bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom}));
    w.op = op;
    return w;
  endfunction

  function automatic logic signed [CoordBits-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CMax;
      1: return CMin;
      2: return CoordBits'($signed($urandom_range(0, 200)) - 100);
      default: return CoordBits'($urandom);
    endcase
  endfunction

  task automatic push_load(logic signed [CoordBits-1:0] x, logic signed [CoordBits-1:0] y,
                           logic signed [CoordBits-1:0] z);
    in_word_t w;
    w = make_word(OpLoad);
    w.pos_x = x; w.pos_y = y; w.pos_z = z;
    pending_words.push_back(w);
  endtask

  task automatic push_tri(int a, int b, int c);
    in_word_t w;
    w = make_word(OpTri);
    w.tri_v0 = IndexBits'(a); w.tri_v1 = IndexBits'(b); w.tri_v2 = IndexBits'(c);
    pending_words.push_back(w);
  endtask

  task automatic push_query(int q);
    in_word_t w;
    w = make_word(OpQuery);
    w.vertex_index = IndexBits'(q);
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
  endtask

  // Builds one mesh of n vertices, some faces and queries; an occasional bad index.
  task automatic push_mesh(int n, int faces, int queries);
    pending_words.push_back(make_word(OpStart));
    for (int i = 0; i < n; i++) push_load(rand_coord(), rand_coord(), rand_coord());
    for (int i = 0; i < faces; i++) begin
      if ($urandom_range(0, 19) == 0) push_tri($urandom, $urandom, $urandom);
      else push_tri($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                    $urandom_range(0, n - 1));
    end
    for (int i = 0; i < queries; i++) begin
      if ($urandom_range(0, 9) == 0) push_query($urandom_range(n, 65535));
      else push_query($urandom_range(0, n - 1));
    end
  endtask

  initial begin
    int phase_items;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    push_query(0);
    push_tri(0, 0, 0);
    push_load(CMax, CMin, 0);
    push_load(CMin, CMax, CMax);
    push_load(0, 0, CMin);
    push_query(0);
    push_tri(0, 1, 2);
    push_tri(0, 1, 2);
    push_tri(0, 0, 1);
    push_tri(0, 1, 3);
    push_tri(65535, 65535, 65535);
    push_query(0);
    push_query(1);
    push_query(2);
    push_query(3);
    push_query(65535);
    for (int i = 0; i < 8; i++) push_tri(0, 1, 2);
    push_query(2);
    pending_words.push_back(make_word(OpStart));
    push_query(0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      phase_items = 0;
      while (phase_items < 350) begin
        if ($urandom_range(0, 7) == 0) begin
          for (int i = 0; i < 6; i++)
            pending_words.push_back(make_word(2'($urandom_range(0, 3))));
          phase_items += 6;
        end else begin
          int n, nf, nq;
          n = $urandom_range(3, 12);
          nf = $urandom_range(2, 10);
          nq = $urandom_range(2, 6);
          push_mesh(n, nf, nq);
          phase_items += n + nf + nq + 1;
        end
      end
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (failed) begin
      $display("FAIL");
    end else begin
      $display("PASS");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!in_valid || in_ready_q) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    cycles <= cycles + 1;
    in_ready_q <= in_valid && in_ready;
    if (in_valid && in_ready) expected_words.push_back(predict_result(in_data));
    if (out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: actual %p", $time, out_data);
        failed = 1'b1;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_data !== exp_w) begin
          $display("%0t mismatch: expected %p actual %p", $time, exp_w, out_data);
          failed = 1'b1;
        end
      end
    end
    if (cycles > 3000000) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
